// ===== hdl/vlpd_pkg.sv =====
// Shared types and constants for the varint length-prefixed deframer.
package vlpd_pkg;

  localparam int MAX_W = 10;
  localparam logic [MAX_W-1:0] MAX_RESET = 10'd512;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_ERROR   = 2'd1;
  localparam logic [1:0] KIND_ABORT   = 2'd2;

  localparam logic ACT_DATA = 1'b0;
  localparam logic ACT_NEW  = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic       first_of_frame;
    logic       last_of_frame;
  } out_item_t;

endpackage

// ===== hdl/vlpd_parser.sv =====
// Prefix decoder and payload counter: parser state and the per-byte step logic.
module vlpd_parser #(
  parameter int BUFFER_BYTES = 512
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  vlpd_pkg::in_item_t      item,
  input  logic [vlpd_pkg::MAX_W-1:0] max_frame_bytes,
  output logic                    result_valid,
  output vlpd_pkg::out_item_t     result
);
  import vlpd_pkg::*;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_CLOSED  = 2'd2;
  localparam logic [2:0] PREFIX_LAST = 3'd4;
  // The register never exceeds 1023, so a larger buffer does not narrow the limit.
  localparam logic [MAX_W-1:0] BUF_CAP =
    (BUFFER_BYTES < (1 << MAX_W)) ? MAX_W'(BUFFER_BYTES) : {MAX_W{1'b1}};

  logic [1:0]       phase, phase_next;
  logic [31:0]      length_accum, length_accum_next;
  logic [2:0]       header_count, header_count_next;
  logic [MAX_W-1:0] payload_left, payload_left_next;
  logic             at_frame_start, at_frame_start_next;

  logic [2:0]       idx;
  logic [2:0]       idx_inc;
  logic [31:0]      shifted;
  logic [31:0]      accum_new;
  logic [32:0]      total;
  logic [MAX_W-1:0] eff_limit;
  logic             last;

  always_comb begin
    idx = (header_count > PREFIX_LAST) ? PREFIX_LAST : header_count;
    idx_inc = idx + 3'd1;
    case (idx)
      3'd0:    shifted = {25'd0, item.data_byte[6:0]};
      3'd1:    shifted = {18'd0, item.data_byte[6:0], 7'd0};
      3'd2:    shifted = {11'd0, item.data_byte[6:0], 14'd0};
      3'd3:    shifted = {4'd0, item.data_byte[6:0], 21'd0};
      default: shifted = {item.data_byte[3:0], 28'd0};
    endcase
    accum_new = length_accum | shifted;
    total = {1'b0, accum_new} + {30'd0, idx_inc};
    eff_limit = (max_frame_bytes > BUF_CAP) ? BUF_CAP : max_frame_bytes;
    last = (payload_left <= MAX_W'(1));
  end

  always_comb begin
    phase_next          = phase;
    length_accum_next   = length_accum;
    header_count_next   = header_count;
    payload_left_next   = payload_left;
    at_frame_start_next = at_frame_start;
    result_valid        = 1'b0;
    result              = '0;

    if (item.action == ACT_NEW) begin
      phase_next          = PH_HEADER;
      length_accum_next   = '0;
      header_count_next   = '0;
      payload_left_next   = '0;
      at_frame_start_next = 1'b1;
      if (phase == PH_PAYLOAD && !at_frame_start) begin
        result_valid = 1'b1;
        result.kind  = KIND_ABORT;
      end
    end else begin
      case (phase)
        PH_HEADER: begin
          if (item.data_byte[7]) begin
            if (idx == PREFIX_LAST) begin
              // prefix too long: close the stream
              phase_next        = PH_CLOSED;
              length_accum_next = '0;
              header_count_next = '0;
              payload_left_next = '0;
              at_frame_start_next = 1'b1;
              result_valid      = 1'b1;
              result.kind       = KIND_ERROR;
            end else begin
              length_accum_next = accum_new;
              header_count_next = idx_inc;
            end
          end else if (total > {23'd0, eff_limit}) begin
            phase_next        = PH_CLOSED;
            length_accum_next = '0;
            header_count_next = '0;
            payload_left_next = '0;
            at_frame_start_next = 1'b1;
            result_valid      = 1'b1;
            result.kind       = KIND_ERROR;
          end else if (accum_new == 32'd0) begin
            // empty frame: drop and await the next prefix
            phase_next        = PH_HEADER;
            length_accum_next = '0;
            header_count_next = '0;
            payload_left_next = '0;
            at_frame_start_next = 1'b1;
          end else begin
            phase_next        = PH_PAYLOAD;
            payload_left_next = accum_new[MAX_W-1:0];
            length_accum_next = '0;
            header_count_next = '0;
            at_frame_start_next = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          result_valid          = 1'b1;
          result.kind           = KIND_PAYLOAD;
          result.payload_byte   = item.data_byte;
          result.first_of_frame = at_frame_start;
          result.last_of_frame  = last;
          at_frame_start_next   = 1'b0;
          if (last) begin
            phase_next          = PH_HEADER;
            length_accum_next   = '0;
            header_count_next   = '0;
            payload_left_next   = '0;
            at_frame_start_next = 1'b1;
          end else begin
            payload_left_next = payload_left - MAX_W'(1);
          end
        end
        default: begin
          // closed: ignore data bytes
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      length_accum   <= '0;
      header_count   <= '0;
      payload_left   <= '0;
      at_frame_start <= 1'b1;
    end else if (step) begin
      phase          <= phase_next;
      length_accum   <= length_accum_next;
      header_count   <= header_count_next;
      payload_left   <= payload_left_next;
      at_frame_start <= at_frame_start_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> payload_left != '0)
    else $error("payload phase with nothing left to pass");

  assert property (@(posedge clk) disable iff (rst)
    header_count <= PREFIX_LAST)
    else $error("prefix byte count beyond the last prefix byte");

  assert property (@(posedge clk) disable iff (rst)
    phase != PH_HEADER |-> length_accum == '0 && header_count == '0)
    else $error("length accumulator not cleared outside the header phase");

endmodule

// ===== hdl/varint_length_prefixed_deframer_core.sv =====
// Top level of the varint length-prefixed deframer: input and result registers.
//
// Takes one stream item per cycle on the byte channel while byte_stall is low:
// a received byte, or a new-connection action that resets the parser. Each
// frame opens with a little-endian base-128 length prefix of one to five bytes;
// the payload bytes that follow come out on the frame channel, one item each,
// with the first and last byte of the frame flagged. A prefix whose fifth byte
// still continues, or a prefix-plus-payload total above the smaller of
// cfg_data's limit and BUFFER_BYTES, yields one error item and closes the
// stream; data bytes are then dropped until a new-connection action. A new
// connection during a frame whose payload has started yields one abort item.
// Empty frames yield nothing. Throughput is one item per cycle while
// frame_stall does not hold the result register: the whole step is a shift-or
// into the length accumulator or a decrement of the payload count, done
// between the input register and the result register. byte_stall follows
// frame_stall combinationally when both registers are full. Write the limit
// only while no item is in flight.
module varint_length_prefixed_deframer_core #(
  parameter int BUFFER_BYTES = 512
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       byte_valid,
  output logic                       byte_stall,
  input  vlpd_pkg::in_item_t         byte_item,
  output logic                       frame_valid,
  input  logic                       frame_stall,
  output vlpd_pkg::out_item_t        frame_item,
  input  logic                       cfg_write,
  input  logic [vlpd_pkg::MAX_W-1:0] cfg_data
);
  import vlpd_pkg::*;

  logic [MAX_W-1:0] max_frame_bytes;
  logic             s1_valid;
  in_item_t         s1_item;
  logic             out_free;
  logic             step;
  logic             accept_in;
  logic             result_valid;
  out_item_t        result;

  // Output register can take a new item when empty or draining this cycle.
  assign out_free   = !frame_valid || !frame_stall;
  assign step       = s1_valid && out_free;
  assign byte_stall = s1_valid && !out_free;
  assign accept_in  = byte_valid && !byte_stall;

  // Limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_bytes <= MAX_RESET;
    end else if (cfg_write) begin
      max_frame_bytes <= cfg_data;
    end
  end

  // Input register: load on accept, empty once the parser has stepped.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept_in) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      s1_item <= byte_item;
    end
  end

  vlpd_parser #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_parser (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .item           (s1_item),
    .max_frame_bytes(max_frame_bytes),
    .result_valid   (result_valid),
    .result         (result)
  );

  // Result register: hold while stalled, otherwise take whatever the step gives.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (out_free) begin
      frame_valid <= step && result_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && result_valid) begin
      frame_item <= result;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    frame_valid && frame_item.kind != KIND_PAYLOAD |->
      frame_item.payload_byte == 8'd0 && !frame_item.first_of_frame &&
      !frame_item.last_of_frame)
    else $error("status item carries payload fields");

  assert property (@(posedge clk) disable iff (rst)
    frame_valid |-> frame_item.kind == KIND_PAYLOAD ||
      frame_item.kind == KIND_ERROR || frame_item.kind == KIND_ABORT)
    else $error("result item with an undefined kind");

  assert property (@(posedge clk)
    rst |=> !frame_valid && !s1_valid)
    else $error("registers not empty after reset");

  assert property (@(posedge clk) disable iff (rst)
    s1_valid && frame_valid && frame_stall |=> s1_valid && $stable(s1_item))
    else $error("held input item lost while the result side stalls");

endmodule

// ===== bench/varint_length_prefixed_deframer_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the varint length-prefixed deframer core.
module varint_length_prefixed_deframer_core_test;
  import vlpd_pkg::*;

  localparam int BUFFER_BYTES = 512;
  localparam int PREFIX_BYTES = 5;
  // Cycles with no item moving on either channel before the run is declared hung.
  localparam int QUIET_LIMIT  = 5000;
  // Margin for an item still inside the core that will never produce a result.
  localparam int DRAIN_CYCLES = 8;

  typedef enum logic [1:0] {PARSE_HEADER, PARSE_PAYLOAD, PARSE_CLOSED} parse_phase_t;

  // How a row is checked: predicted, expected silent, or against a typed-in outcome.
  typedef enum logic [1:0] {ROW_PREDICT, ROW_SILENT, ROW_TYPED} row_check_t;

  typedef struct {
    in_item_t   item;
    row_check_t check;
    out_item_t  want;
  } stim_row_t;

  logic             clk         = 1'b0;
  logic             rst         = 1'b1;
  logic             byte_valid  = 1'b0;
  logic             byte_stall;
  in_item_t         byte_item   = '0;
  logic             frame_valid;
  logic             frame_stall = 1'b0;
  out_item_t        frame_item;
  logic             cfg_write   = 1'b0;
  logic [MAX_W-1:0] cfg_data    = MAX_RESET;

  // Travels alongside byte_item so the monitor knows how to check the item in flight.
  row_check_t row_check = ROW_PREDICT;
  out_item_t  row_want  = '0;

  // Predicted deframer state, advanced once per accepted item.
  parse_phase_t     pr_phase    = PARSE_HEADER;
  logic [31:0]      pr_length   = '0;
  logic [2:0]       pr_hdr_seen = '0;
  logic [9:0]       pr_left     = '0;
  logic             pr_at_start = 1'b1;
  logic [MAX_W-1:0] frame_limit = MAX_RESET;

  out_item_t pending_frames[$];
  stim_row_t stim_rows[$];

  int fail_count     = 0;
  int sent_items     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  varint_length_prefixed_deframer_core #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .frame_valid(frame_valid),
    .frame_stall(frame_stall),
    .frame_item (frame_item),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function void clear_parser();
    pr_phase    = PARSE_HEADER;
    pr_length   = '0;
    pr_hdr_seen = '0;
    pr_left     = '0;
    pr_at_start = 1'b1;
  endfunction

  // Advance the predicted parser by one item; got says whether a frame item results.
  function void deframe_byte(input in_item_t it, output logic got, output out_item_t res);
    logic [2:0]  idx;
    logic [63:0] total;
    logic [63:0] cap;
    got = 1'b0;
    res = '0;
    if (it.action == ACT_NEW) begin
      // Abort only once the frame has shown at least one payload byte.
      got = (pr_phase == PARSE_PAYLOAD) && !pr_at_start;
      clear_parser();
      if (got) res.kind = KIND_ABORT;
    end else begin
      case (pr_phase)
        PARSE_HEADER: begin
          idx = (pr_hdr_seen >= PREFIX_BYTES) ? 3'(PREFIX_BYTES - 1) : pr_hdr_seen;
          // The fifth byte lands at bit 28: anything above bit 31 falls off.
          pr_length |= 32'(it.data_byte[6:0]) << (7 * idx);
          if (it.data_byte[7]) begin
            if (idx + 1 >= PREFIX_BYTES) begin
              clear_parser();
              pr_phase = PARSE_CLOSED;
              got      = 1'b1;
              res.kind = KIND_ERROR;
            end else begin
              pr_hdr_seen = idx + 3'd1;
            end
          end else begin
            // Header plus payload, summed wide so a huge prefix cannot wrap under the limit.
            total = 64'(idx) + 64'd1 + 64'(pr_length);
            cap   = (frame_limit > BUFFER_BYTES) ? 64'(BUFFER_BYTES) : 64'(frame_limit);
            if (total > cap) begin
              clear_parser();
              pr_phase = PARSE_CLOSED;
              got      = 1'b1;
              res.kind = KIND_ERROR;
            end else if (pr_length == '0) begin
              clear_parser();
            end else begin
              pr_left     = pr_length[9:0];
              pr_length   = '0;
              pr_hdr_seen = '0;
              pr_at_start = 1'b1;
              pr_phase    = PARSE_PAYLOAD;
            end
          end
        end
        PARSE_PAYLOAD: begin
          got                = 1'b1;
          res.kind           = KIND_PAYLOAD;
          res.payload_byte   = it.data_byte;
          res.first_of_frame = pr_at_start;
          res.last_of_frame  = (pr_left <= 10'd1);
          pr_at_start        = 1'b0;
          if (res.last_of_frame) clear_parser();
          else pr_left = pr_left - 10'd1;
        end
        default: ;  // closed: drop data bytes
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted byte item, check every accepted frame item
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] seen);
    if (want !== seen) begin
      $display("%0t: frame %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : frame_monitor
    logic      got;
    out_item_t res;
    out_item_t want;
    if (rst) begin
      clear_parser();
      frame_limit = MAX_RESET;
      pending_frames.delete();
    end else begin
      if (cfg_write) frame_limit = cfg_data;
      if (byte_valid && !byte_stall) begin
        deframe_byte(byte_item, got, res);
        // Typed rows carry their own outcome; the predictor still advances its state.
        if (row_check == ROW_TYPED) pending_frames.push_back(row_want);
        else if (row_check == ROW_PREDICT && got) pending_frames.push_back(res);
      end
      if (frame_valid && !frame_stall) begin
        if (pending_frames.size() == 0) begin
          $display("%0t: unexpected frame item, expected none, actual %h", $time, frame_item);
          fail_count++;
        end else begin
          want = pending_frames.pop_front();
          check_field("kind", want.kind, frame_item.kind);
          check_field("payload_byte", want.payload_byte, frame_item.payload_byte);
          check_field("first_of_frame", want.first_of_frame, frame_item.first_of_frame);
          check_field("last_of_frame", want.last_of_frame, frame_item.last_of_frame);
        end
      end
    end
  end

  // Receiver back-pressure at the rate the current phase asks for.
  always @(posedge clk) begin
    frame_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Watchdog: give up when nothing moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (byte_valid && !byte_stall) || (frame_valid && !frame_stall)) quiet = 0;
      else quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic out_item_t result_of(input logic [1:0] kind, input logic [7:0] pbyte,
                                          input logic first, input logic last);
    out_item_t r;
    r.kind           = kind;
    r.payload_byte   = pbyte;
    r.first_of_frame = first;
    r.last_of_frame  = last;
    return r;
  endfunction

  function void add_row(input logic act, input logic [7:0] b, input row_check_t chk,
                        input out_item_t want);
    stim_row_t row;
    row.item.action    = act;
    row.item.data_byte = b;
    row.check          = chk;
    row.want           = want;
    stim_rows.push_back(row);
  endfunction

  // Present one item, idling first at the phase's rate; return at the edge that takes it.
  task automatic send_item(input in_item_t it, input row_check_t chk, input out_item_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_item  <= it;
    row_check  <= chk;
    row_want   <= want;
    do @(posedge clk); while (byte_stall);
    sent_items++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    in_item_t it;
    it.action    = ACT_DATA;
    it.data_byte = b;
    send_item(it, ROW_PREDICT, '0);
  endtask

  task automatic send_new();
    in_item_t it;
    it.action    = ACT_NEW;
    it.data_byte = 8'($urandom_range(0, 255));
    send_item(it, ROW_PREDICT, '0);
  endtask

  // Encode len as a varint of exactly hdr bytes, padding with continuation bytes if asked.
  task automatic send_prefix(input int len, input int hdr);
    logic [7:0] b;
    for (int i = 0; i < hdr; i++) begin
      b = 8'((len >> (7 * i)) & 'h7F);
      if (i < hdr - 1) b[7] = 1'b1;
      send_byte(b);
    end
  endtask

  // One frame's worth of stream: mostly well-formed, the rest broken or noisy.
  task automatic gen_frame(input int eff);
    int hdr;
    int len;
    int room;
    int pick;
    if ($urandom_range(0, 99) < 86) begin
      hdr  = ($urandom_range(0, 7) == 0) ? $urandom_range(2, PREFIX_BYTES) : 1;
      room = eff - hdr;
      if (room < 0) begin
        len = $urandom_range(0, 20);
      end else begin
        // Keep most frames short; fill to the limit only now and then.
        pick = $urandom_range(0, 99);
        if (pick < 2) len = room;
        else if (pick < 6) len = $urandom_range(0, room);
        else if (pick < 20) len = $urandom_range(0, (room < 127) ? room : 127);
        else len = $urandom_range(0, (room < 12) ? room : 12);
      end
      if (len > 127 && hdr < 2) hdr = 2;
      send_prefix(len, hdr);
      // An oversized frame closes the stream: reopen instead of feeding dead bytes.
      if (hdr + len > eff) send_new();
      else repeat (len) send_byte(8'($urandom_range(0, 255)));
    end else begin
      case ($urandom_range(0, 5))
        0: begin
          // prefix still continuing on its fifth byte
          repeat (PREFIX_BYTES) send_byte(8'h80 | 8'($urandom_range(0, 127)));
          repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
        end
        1: begin
          // full five-byte prefix with random value bits, mostly far too large
          repeat (PREFIX_BYTES - 1) send_byte(8'h80 | 8'($urandom_range(0, 127)));
          send_byte(8'($urandom_range(0, 127)));
        end
        2: begin
          // just over the limit
          len = eff + $urandom_range(0, 2);
          send_prefix(len, (len > 127) ? 2 : 1);
          repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
        end
        3: begin
          // frame cut short by a new connection
          len = $urandom_range(1, 16);
          send_prefix(len, 1);
          repeat ($urandom_range(0, len - 1)) send_byte(8'($urandom_range(0, 255)));
        end
        4: repeat ($urandom_range(1, PREFIX_BYTES - 1))
             send_byte(8'h80 | 8'($urandom_range(0, 127)));
        default: ;
      endcase
      send_new();
    end
  endtask

  // Hold off the sender until every expected frame item is back and the core is quiet.
  task automatic drain();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [MAX_W-1:0] lim, input int idle, input int stall,
                           input int budget, input bit pause_mid);
    int eff;
    drain();
    cfg_write      <= 1'b1;
    cfg_data       <= lim;
    recv_stall_pct <= stall;
    send_idle_pct   = idle;
    @(posedge clk);
    cfg_write <= 1'b0;
    eff        = (lim > BUFFER_BYTES) ? BUFFER_BYTES : int'(lim);
    sent_items = 0;
    // Keep going until the item budget is spent.
    while (sent_items < budget) begin
      if (pause_mid && sent_items >= budget / 2) begin
        pause_mid = 1'b0;
        drain();
      end
      gen_frame(eff);
    end
  endtask

  initial begin
    // Directed stream, run at the reset limit with no idling.
    add_row(ACT_NEW,  8'h00, ROW_SILENT,  '0);  // new connection straight after reset
    add_row(ACT_DATA, 8'h00, ROW_SILENT,  '0);  // zero-length frame
    add_row(ACT_DATA, 8'h03, ROW_SILENT,  '0);  // three-byte frame
    add_row(ACT_DATA, 8'hFF, ROW_TYPED,   result_of(KIND_PAYLOAD, 8'hFF, 1'b1, 1'b0));
    add_row(ACT_DATA, 8'h00, ROW_PREDICT, '0);
    add_row(ACT_DATA, 8'h5A, ROW_TYPED,   result_of(KIND_PAYLOAD, 8'h5A, 1'b0, 1'b1));
    add_row(ACT_DATA, 8'h01, ROW_SILENT,  '0);  // one-byte frame: first and last at once
    add_row(ACT_DATA, 8'hA5, ROW_TYPED,   result_of(KIND_PAYLOAD, 8'hA5, 1'b1, 1'b1));
    add_row(ACT_DATA, 8'h02, ROW_SILENT,  '0);
    add_row(ACT_DATA, 8'h11, ROW_PREDICT, '0);
    add_row(ACT_NEW,  8'hFF, ROW_TYPED,   result_of(KIND_ABORT, 8'h00, 1'b0, 1'b0));
    // prefix whose fifth byte still continues
    repeat (PREFIX_BYTES - 1) add_row(ACT_DATA, 8'h80, ROW_SILENT, '0);
    add_row(ACT_DATA, 8'h80, ROW_TYPED,   result_of(KIND_ERROR, 8'h00, 1'b0, 1'b0));
    add_row(ACT_DATA, 8'h7F, ROW_SILENT,  '0);  // dropped while closed
    add_row(ACT_NEW,  8'h00, ROW_SILENT,  '0);
    // value bits pushed above bit 31 vanish, leaving an empty frame
    repeat (PREFIX_BYTES - 1) add_row(ACT_DATA, 8'h80, ROW_SILENT, '0);
    add_row(ACT_DATA, 8'h70, ROW_SILENT,  '0);
    // length 512 behind a two-byte prefix overruns the limit
    add_row(ACT_DATA, 8'h80, ROW_SILENT,  '0);
    add_row(ACT_DATA, 8'h04, ROW_TYPED,   result_of(KIND_ERROR, 8'h00, 1'b0, 1'b0));
    add_row(ACT_NEW,  8'h00, ROW_SILENT,  '0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i]) send_item(stim_rows[i].item, stim_rows[i].check, stim_rows[i].want);

    // Random phases: limit, sender idle %, receiver stall %, item budget, mid-phase hold.
    run_phase(MAX_RESET, 0, 0, 500, 1'b0);
    run_phase('0, 80, 0, 100, 1'b0);
    run_phase('1, 0, 80, 450, 1'b1);
    run_phase(MAX_W'(1), 9, 9, 100, 1'b0);
    run_phase(MAX_W'($urandom_range(2, 511)), 9, 9, 450, 1'b0);
    run_phase(MAX_W'(64), 80, 0, 300, 1'b0);

    drain();
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
